@@ rtl/core/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg
// shared types, constants and saturating coefficient add of the sparse polynomial adder
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int unsigned MaxTermsDef = 16;
  localparam int unsigned CoefW       = 32;
  localparam int unsigned ExpW        = 16;
  localparam int unsigned TermW       = CoefW + ExpW;

  typedef enum logic [1:0] {
    ACT_ADD_A   = 2'd0,
    ACT_ADD_B   = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_LAST,
    ST_MRG,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic signed [ExpW-1:0]  expo;
  } term_t;

  function automatic logic signed [CoefW-1:0] sat_add(
    input logic signed [CoefW-1:0] x,
    input logic signed [CoefW-1:0] y
  );
    logic signed [CoefW:0] s;
    logic signed [CoefW-1:0] r;
    s = {x[CoefW-1], x} + {y[CoefW-1], y};
    if (s[CoefW] != s[CoefW-1]) begin
      r = s[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      r = s[CoefW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/spa_ram.sv @@
// ----------------------------------------------------------------------------
// spa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sparse_polynomial_adder.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// two sorted term tables in ram, merged and summed on a compute command
// ----------------------------------------------------------------------------
// add term: written straight into an empty table, else stored entries with
//   larger exponents shift up; the shift walks the table ram one entry a cycle
// compute: one merge step per A term, B term or matched pair, held while the
//   output stream is stalled; results pass through a one-deep output register
// reset: term counts, overflow flag and output valid clear at once, table
//   contents are left undefined and their unwritten entries are never used
module sparse_polynomial_adder
  import spa_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [47:0]      s_axis_tdata_i,  // coef [31:0], exponent [47:32]
  input  logic [1:0]       s_axis_tuser_i,  // action [1:0]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // sum_coef [31:0], sum_exponent [47:32]
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o   // empty_res [0], overflow [1]
);

  localparam int unsigned AW = $clog2(MaxTerms);
  localparam int unsigned CW = $clog2(MaxTerms + 1);

  state_e state_q, state_d;

  logic [CW-1:0] na_q, na_d, nb_q, nb_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [AW-1:0] k_q, k_d;
  logic          drop_q, drop_d;
  logic          tsel_q, tsel_d;
  term_t         t_q, t_d;

  logic          hold_valid_q, hold_valid_d;
  term_t         hold_q, hold_d;

  logic          out_valid_q, out_valid_d;
  term_t         out_q, out_d;
  logic          out_last_q, out_last_d;
  logic          out_empty_q, out_empty_d;
  logic          out_ovf_q, out_ovf_d;

  // ram ports
  logic          we_a, we_b, re;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  term_t         wdata;
  logic [TermW-1:0] rdata_a_raw, rdata_b_raw;
  term_t         rd_a, rd_b, rd_sel;

  spa_ram #(.Width(TermW), .Depth(MaxTerms)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a_raw)
  );

  spa_ram #(.Width(TermW), .Depth(MaxTerms)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b_raw)
  );

  assign rd_a   = term_t'(rdata_a_raw);
  assign rd_b   = term_t'(rdata_b_raw);
  assign rd_sel = tsel_q ? rd_b : rd_a;

  // input decode
  logic          in_fire;
  action_e       in_act;
  term_t         in_term;
  logic          in_marker;
  logic [CW-1:0] in_cnt, in_cnt_m1;
  logic          in_sel;
  logic          in_room;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_act    = action_e'(s_axis_tuser_i);
  assign in_term.coef = s_axis_tdata_i[31:0];
  assign in_term.expo = s_axis_tdata_i[47:32];
  assign in_marker = (in_term.coef == '0) && (in_term.expo == '0);
  assign in_sel    = (in_act == ACT_ADD_B);
  assign in_cnt    = in_sel ? nb_q : na_q;
  assign in_cnt_m1 = in_cnt - CW'(1);
  assign in_room   = (in_cnt < CW'(MaxTerms));

  // insertion compare: stored entry moves up while its exponent is larger
  logic shift;
  assign shift = (rd_sel.expo > t_q.expo);

  // merge step
  logic              out_free;
  logic              a_av, b_av, mrg_done;
  logic              take_a, take_b;
  logic signed [CoefW-1:0] pair_sum;
  logic              emit;
  term_t             emit_term;
  logic              mrg_stall;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign a_av      = (i_q < na_q);
  assign b_av      = (j_q < nb_q);
  assign mrg_done  = !a_av && !b_av;
  assign take_a    = !b_av || (a_av && (rd_a.expo < rd_b.expo));
  assign take_b    = !take_a && (!a_av || (rd_b.expo < rd_a.expo));
  assign pair_sum  = sat_add(rd_a.coef, rd_b.coef);
  assign emit      = take_a || take_b || (pair_sum != '0);
  assign mrg_stall = emit && hold_valid_q && !out_free;

  always_comb begin
    emit_term = rd_a;
    if (take_b) begin
      emit_term = rd_b;
    end else if (!take_a) begin
      emit_term.coef = pair_sum;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_ADD_A, ACT_ADD_B: begin
              if (!in_marker && in_room && (in_cnt != '0)) begin
                state_d = ST_INS;
              end
            end
            ACT_COMPUTE: state_d = ST_MRG;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS: begin
        if (shift) begin
          state_d = (k_q == '0) ? ST_INS_LAST : ST_INS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_INS_LAST: state_d = ST_IDLE;
      ST_MRG: begin
        if (mrg_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    na_d         = na_q;
    nb_d         = nb_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    drop_d       = drop_q;
    tsel_d       = tsel_q;
    t_d          = t_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_ovf_d    = out_ovf_q;

    we_a    = 1'b0;
    we_b    = 1'b0;
    re      = 1'b0;
    waddr   = '0;
    wdata   = t_q;
    raddr_a = k_q;
    raddr_b = k_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_ADD_A, ACT_ADD_B: begin
              tsel_d = in_sel;
              t_d    = in_term;
              if (!in_marker) begin
                if (!in_room) begin
                  drop_d = 1'b1;
                end else if (in_cnt == '0) begin
                  // empty table: write straight to the first entry
                  we_a  = !in_sel;
                  we_b  = in_sel;
                  waddr = '0;
                  wdata = in_term;
                  if (in_sel) nb_d = CW'(1);
                  else        na_d = CW'(1);
                end else begin
                  re      = 1'b1;
                  raddr_a = in_cnt_m1[AW-1:0];
                  raddr_b = in_cnt_m1[AW-1:0];
                  k_d     = in_cnt_m1[AW-1:0];
                end
              end
            end
            ACT_COMPUTE: begin
              re           = 1'b1;
              raddr_a      = '0;
              raddr_b      = '0;
              i_d          = '0;
              j_d          = '0;
              hold_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_INS: begin
        we_a  = !tsel_q;
        we_b  = tsel_q;
        waddr = k_q + AW'(1);
        if (shift) begin
          wdata = rd_sel;
          if (k_q != '0) begin
            re      = 1'b1;
            raddr_a = k_q - AW'(1);
            raddr_b = k_q - AW'(1);
            k_d     = k_q - AW'(1);
          end
        end else begin
          wdata = t_q;
          if (tsel_q) nb_d = nb_q + CW'(1);
          else        na_d = na_q + CW'(1);
        end
      end
      ST_INS_LAST: begin
        we_a  = !tsel_q;
        we_b  = tsel_q;
        waddr = '0;
        wdata = t_q;
        if (tsel_q) nb_d = nb_q + CW'(1);
        else        na_d = na_q + CW'(1);
      end
      ST_MRG: begin
        // a result is held back one step so the final one can carry tlast
        if (!mrg_done && !mrg_stall) begin
          if (emit) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = hold_q;
              out_last_d  = 1'b0;
              out_empty_d = 1'b0;
              out_ovf_d   = drop_q;
            end
            hold_valid_d = 1'b1;
            hold_d       = emit_term;
          end
          if (!take_b) i_d = i_q + CW'(1);
          if (!take_a) j_d = j_q + CW'(1);
          re      = 1'b1;
          raddr_a = i_d[AW-1:0];
          raddr_b = j_d[AW-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_ovf_d    = drop_q;
          out_empty_d  = !hold_valid_q;
          out_d        = hold_valid_q ? hold_q : term_t'('0);
          hold_valid_d = 1'b0;
          na_d         = '0;
          nb_d         = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      na_q         <= '0;
      nb_q         <= '0;
      drop_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      na_q         <= na_d;
      nb_q         <= nb_d;
      drop_q       <= drop_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    tsel_q      <= tsel_d;
    t_q         <= t_d;
    hold_q      <= hold_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.expo, out_q.coef};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_empty_q};

endmodule
